### design/identifier_allocator_top_assert.svh
// assertion macros for the identifier allocator checker
`ifndef IDENTIFIER_ALLOCATOR_TOP_ASSERT_SVH
`define IDENTIFIER_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication, reset disabled
`define IDAL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("identifier allocator assertion failed");

// next-cycle implication, reset disabled
`define IDAL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("identifier allocator assertion failed");

`endif

### design/idal_pkg.sv
// types, codes and cell update functions of the identifier allocator
`timescale 1ns / 1ps
`default_nettype none
package idal_pkg;

  localparam int unsigned IdentWidth = 6;
  localparam int unsigned CountWidth = 4;
  localparam logic [CountWidth-1:0] CountMax = 4'd15;

  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_CLAIM   = 2'd1;
  localparam logic [1:0] FUNC_RELEASE = 2'd2;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_EXHAUSTED = 1'b1;

  typedef struct packed {
    logic [1:0]            func;
    logic [IdentWidth-1:0] ident;
  } req_t;

  typedef struct packed {
    logic [IdentWidth-1:0] result_id;
    logic                  status;
  } rsp_t;

  typedef struct packed {
    logic [CountWidth-1:0] count;
    logic                  released;
  } cell_t;

  // ring control from the sequencer to the cell row
  typedef struct packed {
    logic  shift;
    cell_t data;
  } ring_ctl_t;

  function automatic cell_t cell_take(cell_t c);
    cell_t r;
    r = c;
    r.released = 1'b0;
    if (c.count != CountMax) begin
      r.count = c.count + 4'd1;
    end
    return r;
  endfunction

  function automatic cell_t cell_give(cell_t c);
    cell_t r;
    r = c;
    r.released = 1'b1;
    if (c.count != '0) begin
      r.count = c.count - 4'd1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### design/idal_cell.sv
// one table entry of the rotating ring: use count and released flag
`timescale 1ns / 1ps
`default_nettype none
module idal_cell
  import idal_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   shift_i,
  input  cell_t data_i,
  output cell_t data_o
);

  cell_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (shift_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

### design/idal_ctrl.sv
// sequencer: scans the ring head, applies updates, holds the response register
`timescale 1ns / 1ps
`default_nettype none
module idal_ctrl
  import idal_pkg::*;
#(
  parameter int NUM_IDS  = 64,
  parameter int FIRST_ID = 1
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_ready_o,
  input  req_t      in_req_i,
  output logic      out_valid_o,
  input  wire       out_ready_i,
  output rsp_t      out_rsp_o,
  input  cell_t     head_i,
  output ring_ctl_t ring_o
);

  localparam int IW = $clog2(NUM_IDS);
  localparam int EW = ((IW > IdentWidth) ? IW : IdentWidth) + 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PASS1 = 2'd1;
  localparam logic [1:0] S_PASS2 = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [1:0]            func_q, func_d;
  logic [IdentWidth-1:0] ident_q, ident_d;
  logic [IW-1:0]         pos_q, pos_d;
  logic [IW-1:0]         top_q, top_d;
  logic [IW-1:0]         pick_q, pick_d;
  logic                  found_q, found_d;
  logic                  any_used_q, any_used_d;
  rsp_t                  rsp_q, rsp_d;
  logic                  out_valid_q, out_valid_d;
  rsp_t                  out_rsp_q, out_rsp_d;

  logic                  at_end;
  logic                  ident_hit;
  logic                  in_range;
  logic                  alloc_hit;
  logic                  take_here;
  logic                  give_here;
  logic                  any_used_nx;
  logic [IW-1:0]         top_nx;
  logic [IW:0]           cand;
  cell_t                 head_new;

  assign at_end    = (pos_q == IW'(NUM_IDS - 1));
  assign ident_hit = (EW'(ident_q) == EW'(pos_q));
  assign in_range  = (EW'(in_req_i.ident) < EW'(NUM_IDS));

  assign alloc_hit = (state_q == S_PASS1) && (func_q == FUNC_ALLOC) && !found_q &&
                     head_i.released;
  assign take_here = alloc_hit ||
                     ((state_q == S_PASS2) && (pos_q == pick_q)) ||
                     ((state_q == S_PASS1) && (func_q == FUNC_CLAIM) && ident_hit);
  assign give_here = (state_q == S_PASS1) && (func_q == FUNC_RELEASE) && ident_hit;

  always_comb begin
    if (take_here) begin
      head_new = cell_take(head_i);
    end else if (give_here) begin
      head_new = cell_give(head_i);
    end else begin
      head_new = head_i;
    end
  end

  // highest in-use entry seen so far, this cycle's head included
  assign any_used_nx = any_used_q || (head_i.count != '0);
  assign top_nx      = (head_i.count != '0) ? pos_q : top_q;
  assign cand        = any_used_nx ? ({1'b0, top_nx} + (IW+1)'(1)) : (IW+1)'(FIRST_ID);

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    ident_d     = ident_q;
    pos_d       = pos_q;
    top_d       = top_q;
    pick_d      = pick_q;
    found_d     = found_q;
    any_used_d  = any_used_q;
    rsp_d       = rsp_q;
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d          = in_req_i.func;
          ident_d         = in_req_i.ident;
          found_d         = 1'b0;
          any_used_d      = 1'b0;
          top_d           = '0;
          pos_d           = '0;
          rsp_d.result_id = in_req_i.ident;
          rsp_d.status    = STATUS_OK;
          if ((in_req_i.func == FUNC_ALLOC) ||
              (((in_req_i.func == FUNC_CLAIM) || (in_req_i.func == FUNC_RELEASE)) &&
               in_range)) begin
            state_d = S_PASS1;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_PASS1: begin
        pos_d      = pos_q + IW'(1);
        any_used_d = any_used_nx;
        top_d      = top_nx;
        if (alloc_hit) begin
          found_d         = 1'b1;
          rsp_d.result_id = IdentWidth'(pos_q);
        end
        if (at_end) begin
          pos_d   = '0;
          state_d = S_RESP;
          if ((func_q == FUNC_ALLOC) && !found_q && !alloc_hit) begin
            if (cand < (IW+1)'(NUM_IDS)) begin
              pick_d          = IW'(cand);
              rsp_d.result_id = IdentWidth'(cand);
              state_d         = S_PASS2;
            end else begin
              rsp_d.result_id = '0;
              rsp_d.status    = STATUS_EXHAUSTED;
            end
          end
        end
      end
      S_PASS2: begin
        pos_d = pos_q + IW'(1);
        if (at_end) begin
          pos_d   = '0;
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_rsp_d   = rsp_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    ident_q    <= ident_d;
    top_q      <= top_d;
    pick_q     <= pick_d;
    found_q    <= found_d;
    any_used_q <= any_used_d;
    rsp_q      <= rsp_d;
    out_rsp_q  <= out_rsp_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;
  assign ring_o.shift = (state_q == S_PASS1) || (state_q == S_PASS2);
  assign ring_o.data  = head_new;

endmodule
`default_nettype wire

### design/identifier_allocator_top.sv
// Identifier allocator, top level: a ring of NUM_IDS table cells and a sequencer.
// Requests arrive on in_valid_i/in_ready_o with in_req_i (func, ident); each
// request yields exactly one response on out_valid_o/out_ready_i with out_rsp_o.
// The table lives in a ring of cells that rotates by one entry per cycle while a
// scan runs; the sequencer sees and rewrites only the cell at the head of the
// ring. Allocate scans one full revolution for the lowest released and highest
// in-use entry; if nothing is released it takes a second revolution to update
// the picked entry. Claim and release take one revolution. An unused code or an
// out-of-range identifier skips the scan and goes straight to the response.
// One request is in flight at a time; in_ready_o is high only while the
// sequencer is idle.
// The response sits in an output register; a new request is taken while it
// waits, and a finished response waits in the sequencer until the register
// frees up when the receiver stalls.
// Reset clears every cell (count zero, not released) at once; no sweep needed.
`timescale 1ns / 1ps
`default_nettype none
module identifier_allocator_top
  import idal_pkg::*;
#(
  parameter int NUM_IDS  = 64,
  parameter int FIRST_ID = 1
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  wire  out_ready_i,
  output rsp_t out_rsp_o
);

  cell_t     cell_data [NUM_IDS];
  ring_ctl_t ring;

  idal_ctrl #(
    .NUM_IDS  (NUM_IDS),
    .FIRST_ID (FIRST_ID)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .head_i      (cell_data[0]),
    .ring_o      (ring)
  );

  // cell k takes from cell k+1; the last cell takes the rewritten head
  for (genvar k = 0; k < NUM_IDS; k++) begin : g_cell
    cell_t nbr;
    if (k == NUM_IDS - 1) begin : g_tail
      assign nbr = ring.data;
    end else begin : g_body
      assign nbr = cell_data[k+1];
    end
    idal_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (ring.shift),
      .data_i  (nbr),
      .data_o  (cell_data[k])
    );
  end

endmodule
`default_nettype wire

### design/idal_checker.sv
// port-level checker for the identifier allocator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "identifier_allocator_top_assert.svh"
module idal_checker
  import idal_pkg::*;
(
  input wire  clk_i,
  input wire  rst_ni,
  input wire  in_valid_i,
  input wire  in_ready_o,
  input req_t in_req_i,
  input wire  out_valid_o,
  input wire  out_ready_i,
  input rsp_t out_rsp_o
);

  // a stalled response holds
  `IDAL_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_rsp_o))

  // exhausted allocate hands out no identifier
  `IDAL_ASSERT_NOW(a_exhausted_zero, out_valid_o && (out_rsp_o.status == STATUS_EXHAUSTED),
                   out_rsp_o.result_id == '0)

  // one request in flight: busy right after a request is taken
  `IDAL_ASSERT_NEXT(a_busy_after_req, in_valid_i && in_ready_o, !in_ready_o)

endmodule

bind identifier_allocator_top idal_checker u_idal_checker (.*);
`default_nettype wire
